>>> src/cpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel pool allocator package
// Request codes, channel kinds and the command/status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package cpa_pkg;

	// Field widths of the stream payloads
	localparam int REQ_W   = 4;
	localparam int ID_W    = 8;
	localparam int COUNT_W = 9;
	localparam int KIND_W  = 2;
	localparam int OSINK_W = 16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ADD_RANGE  = 4'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY      = 4'd1;
	localparam logic [REQ_W-1:0] REQ_SET_ACTIVE = 4'd2;
	localparam logic [REQ_W-1:0] REQ_SET_STD    = 4'd3;
	localparam logic [REQ_W-1:0] REQ_SET_CAND   = 4'd4;
	localparam logic [REQ_W-1:0] REQ_ADD_SINK   = 4'd5;
	localparam logic [REQ_W-1:0] REQ_REM_SINK   = 4'd6;
	localparam logic [REQ_W-1:0] REQ_ALLOC_PLN  = 4'd7;
	localparam logic [REQ_W-1:0] REQ_ALLOC_STD  = 4'd8;
	localparam logic [REQ_W-1:0] REQ_INFO       = 4'd9;

	// Channel kinds
	localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CAND  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture the request on an input transfer
		logic read;   // read the entry, build the free-channel match vector
		logic find1;  // pick the lowest group holding a match
		logic find2;  // pick the lowest match inside that group
		logic exec;   // update the table and load the result register
	} cpa_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic alloc;  // captured request is an allocation
	} cpa_sts_t;

endpackage
`default_nettype wire

>>> src/cpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel pool allocator controller
// Sequences one request through read, search and execute steps and owns the
// input ready and the result valid flag.
// ----------------------------------------------------------------------------
module cpa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	input  wire cpa_pkg::cpa_sts_t sts,
	output cpa_pkg::cpa_cmd_t    cmd
);
	import cpa_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_FIND1 = 3'd2;
	localparam logic [2:0] ST_FIND2 = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_vld_q;
	logic       exec_go;

	// Execute only when the result register is free or being drained
	assign exec_go  = (state_q == ST_EXEC) && (!out_vld_q || m_tready);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.exec  = exec_go;
		case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid) state_d = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = sts.alloc ? ST_FIND1 : ST_EXEC;
			end
			ST_FIND1: begin
				cmd.find1 = 1'b1;
				state_d   = ST_FIND2;
			end
			ST_FIND2: begin
				cmd.find2 = 1'b1;
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				if (exec_go) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> src/cpa_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel pool allocator datapath
// Channel flag vectors, sink count memory, two-level lowest-free search and
// the result register.
// ----------------------------------------------------------------------------
module cpa_dp #(
	parameter int NUM_CHANNELS = 256,
	parameter int SINK_BITS    = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cpa_pkg::cpa_cmd_t             cmd,
	output cpa_pkg::cpa_sts_t                  sts,
	input  wire logic [cpa_pkg::REQ_W-1:0]     req_type,
	input  wire logic [cpa_pkg::ID_W-1:0]      chan_id,
	input  wire logic [cpa_pkg::COUNT_W-1:0]   range_count,
	input  wire logic                          active_value,
	output logic                               status,
	output logic [cpa_pkg::ID_W-1:0]           found_id,
	output logic                               is_active,
	output logic [cpa_pkg::KIND_W-1:0]         chan_kind,
	output logic [cpa_pkg::OSINK_W-1:0]        sink_count
);
	import cpa_pkg::*;

	localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int GS     = 16;
	localparam int LOW_W  = 4;
	localparam int NGRP   = (NUM_CHANNELS + GS - 1) / GS;
	localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int FW     = GRP_W + LOW_W;
	localparam int CW     = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
	localparam int IW     = IDX_W + ID_W;
	localparam logic [SINK_BITS-1:0] SINK_MAX = {SINK_BITS{1'b1}};

	// Captured request
	logic [REQ_W-1:0]   req_q;
	logic [ID_W-1:0]    id_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               act_q;

	// Channel table
	logic [NUM_CHANNELS-1:0] present_q, present_d;
	logic [NUM_CHANNELS-1:0] active_q, active_d;
	logic [KIND_W-1:0]       kind_q [NUM_CHANNELS];
	logic [KIND_W-1:0]       kind_d [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] sink_vld_q;
	logic [SINK_BITS-1:0]    sink_mem [NUM_CHANNELS];

	// Read and search stages
	logic [SINK_BITS-1:0] sink_rd_q;
	logic                 sink_rv_q;
	logic [GS-1:0]        match_q [NGRP];
	logic [NGRP-1:0]      grp_any_q;
	logic [GRP_W-1:0]     grp_q;
	logic                 any_q;
	logic [FW-1:0]        found_q;

	// Request decode and entry lookup
	logic [IW-1:0]        id_wide;
	logic [IDX_W-1:0]     id_idx;
	logic                 id_in;
	logic                 ok;
	logic                 want_plain;
	logic [GS-1:0]        match_c [NGRP];
	logic [NGRP-1:0]      grp_any_c;
	logic [GRP_W-1:0]     grp_c;
	logic [LOW_W-1:0]     low_c;
	logic [GS-1:0]        grp_bits;
	logic [CW-1:0]        rng_lo, rng_hi;
	logic                 is_alloc;
	logic                 alloc_ok;
	logic [SINK_BITS-1:0] sink_cur;
	logic [SINK_BITS-1:0] sink_nx;
	logic                 sink_we;
	logic [SINK_BITS+OSINK_W-1:0] sink_wide;
	logic [FW+ID_W-1:0]   found_wide;

	// Result next values
	logic                 res_status;
	logic [ID_W-1:0]      res_found;
	logic                 res_act;
	logic [KIND_W-1:0]    res_kind;
	logic [OSINK_W-1:0]   res_sink;

	assign id_wide    = IW'(id_q);
	assign id_idx     = id_wide[IDX_W-1:0];
	assign id_in      = id_wide < IW'(NUM_CHANNELS);
	assign ok         = id_in && present_q[id_idx];
	assign want_plain = (req_q == REQ_ALLOC_PLN);
	assign is_alloc   = (req_q == REQ_ALLOC_PLN) || (req_q == REQ_ALLOC_STD);
	assign alloc_ok   = is_alloc && any_q;
	assign sts.alloc  = is_alloc;
	assign rng_lo     = CW'(id_q);
	assign rng_hi     = CW'(id_q) + CW'(cnt_q);

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			id_q  <= chan_id;
			cnt_q <= range_count;
			act_q <= active_value;
		end
	end

	// Free-channel match vector, grouped by sixteen
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			for (int b = 0; b < GS; b++) begin
				match_c[g][b] = 1'b0;
				if (g * GS + b < NUM_CHANNELS) begin
					match_c[g][b] = present_q[g * GS + b] && !active_q[g * GS + b] &&
						(want_plain ? (kind_q[g * GS + b] == KIND_PLAIN) :
						((kind_q[g * GS + b] == KIND_STD) ||
						 (kind_q[g * GS + b] == KIND_CAND)));
				end
			end
			grp_any_c[g] = |match_c[g];
		end
	end

	// Entry read and match capture
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			sink_rd_q <= sink_mem[id_idx];
			match_q   <= match_c;
			grp_any_q <= grp_any_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_rv_q <= 1'b0;
		end else if (cmd.read) begin
			sink_rv_q <= id_in && sink_vld_q[id_idx];
		end
	end

	// Lowest group with a free channel
	always_comb begin
		grp_c = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_q[g]) grp_c = GRP_W'(g);
		end
	end

	// Lowest free channel inside the chosen group
	always_comb begin
		grp_bits = match_q[grp_q];
		low_c    = '0;
		for (int b = GS - 1; b >= 0; b--) begin
			if (grp_bits[b]) low_c = LOW_W'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.find1) begin
			grp_q <= grp_c;
			any_q <= |grp_any_q;
		end
		if (cmd.find2) begin
			found_q <= {grp_q, low_c};
		end
	end

	// Sink count update with saturation
	always_comb begin
		sink_cur = sink_rv_q ? sink_rd_q : '0;
		sink_nx  = sink_cur;
		sink_we  = 1'b0;
		if (req_q == REQ_ADD_SINK) begin
			sink_we = ok;
			if (sink_cur != SINK_MAX) sink_nx = sink_cur + 1'b1;
		end else if (req_q == REQ_REM_SINK) begin
			sink_we = ok;
			if (sink_cur != '0) sink_nx = sink_cur - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && sink_we) sink_mem[id_idx] <= sink_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_vld_q <= '0;
		end else if (cmd.exec && sink_we) begin
			sink_vld_q[id_idx] <= 1'b1;
		end
	end

	// Flag updates
	always_comb begin
		present_d = present_q;
		active_d  = active_q;
		kind_d    = kind_q;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (req_q == REQ_ADD_RANGE && CW'(i) >= rng_lo && CW'(i) < rng_hi) begin
				present_d[i] = 1'b1;
				active_d[i]  = 1'b0;
				kind_d[i]    = KIND_PLAIN;
			end
			if (alloc_ok && FW'(i) == found_q) active_d[i] = 1'b1;
		end
		if (ok && req_q == REQ_SET_ACTIVE) active_d[id_idx] = act_q;
		if (ok && req_q == REQ_SET_STD) kind_d[id_idx] = KIND_STD;
		if (ok && req_q == REQ_SET_CAND) kind_d[id_idx] = KIND_CAND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			active_q  <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) kind_q[i] <= KIND_PLAIN;
		end else if (cmd.exec) begin
			present_q <= present_d;
			active_q  <= active_d;
			kind_q    <= kind_d;
		end
	end

	// Result fields
	assign sink_wide  = (SINK_BITS + OSINK_W)'(sink_cur);
	assign found_wide = (FW + ID_W)'(found_q);

	always_comb begin
		res_status = 1'b1;
		res_found  = '0;
		res_act    = 1'b0;
		res_kind   = KIND_PLAIN;
		res_sink   = '0;
		case (req_q)
			REQ_ADD_RANGE: begin
				res_status = 1'b0;
			end
			REQ_QUERY: begin
				res_status = !ok;
				res_act    = ok && active_q[id_idx];
			end
			REQ_SET_ACTIVE, REQ_SET_STD, REQ_SET_CAND, REQ_ADD_SINK, REQ_REM_SINK: begin
				res_status = !ok;
			end
			REQ_ALLOC_PLN, REQ_ALLOC_STD: begin
				res_status = !any_q;
				if (any_q) res_found = found_wide[ID_W-1:0];
			end
			REQ_INFO: begin
				res_status = !ok;
				if (ok) begin
					res_act  = active_q[id_idx];
					res_kind = kind_q[id_idx];
					res_sink = sink_wide[OSINK_W-1:0];
				end
			end
			default: begin
				res_status = 1'b1;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status     <= res_status;
			found_id   <= res_found;
			is_active  <= res_act;
			chan_kind  <= res_kind;
			sink_count <= res_sink;
		end
	end

endmodule
`default_nettype wire

>>> src/channel_pool_allocator_unit.sv
// Channel pool allocator: one result per request, in order.
// The result register is loaded after the entry read, the two-step lowest-free
// search (allocations only) and the table update.
// Requests are taken one at a time, each once the previous one has updated the
// table; the next request is taken while an earlier result still waits on the output.
// Reset: all channels absent, inactive, plain, sink counts zero; no sweep needed.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel pool allocator unit
// Channel table with range registration, per-channel updates and lowest-free
// allocation, behind stream input and output channels.
// ----------------------------------------------------------------------------
module channel_pool_allocator_unit #(
	parameter int NUM_CHANNELS = 256,
	parameter int SINK_BITS    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// req_type[3:0], chan_id[11:4], range_count[20:12], active_value[21], zero
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// status[0], found_id[8:1], is_active[9], chan_kind[11:10],
	// sink_count[27:12], zero
	output logic [31:0]      m_tdata
);
	import cpa_pkg::*;

	cpa_cmd_t           cmd;
	cpa_sts_t           sts;
	logic               status;
	logic [ID_W-1:0]    found_id;
	logic               is_active;
	logic [KIND_W-1:0]  chan_kind;
	logic [OSINK_W-1:0] sink_count;

	cpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpa_dp #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.SINK_BITS    (SINK_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (s_tdata[3:0]),
		.chan_id      (s_tdata[11:4]),
		.range_count  (s_tdata[20:12]),
		.active_value (s_tdata[21]),
		.status       (status),
		.found_id     (found_id),
		.is_active    (is_active),
		.chan_kind    (chan_kind),
		.sink_count   (sink_count)
	);

	// Result packing
	assign m_tdata = {4'b0000, sink_count, chan_kind, is_active, found_id, status};

endmodule
`default_nettype wire

>>> verif/tb_channel_pool_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel pool allocator unit testbench
// Sends requests over the input stream and compares each result against a
// behavioral copy of the channel table. Directed tests cover absent channels,
// every request kind, range registration past the table end, the sink-count
// floor, a back-to-back sink burst and empty searches. A long random run
// follows, with random gaps on the input stream and random backpressure on
// the output stream.
// ----------------------------------------------------------------------------
module tb_channel_pool_allocator_unit;
	import cpa_pkg::*;

	localparam int NUM_CH         = 256;
	localparam int RANDOM_ITEMS   = 900;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int SINK_BURST     = 20;

	localparam logic [OSINK_W-1:0] SINK_MAX = '1;
	localparam logic               ST_OK    = 1'b0;
	localparam logic               ST_FAIL  = 1'b1;

	// Request codes the block does not implement
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_INFO + 4'd1;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'hF;

	typedef struct packed {
		logic               status;
		logic [ID_W-1:0]    found_id;
		logic               is_active;
		logic [KIND_W-1:0]  chan_kind;
		logic [OSINK_W-1:0] sink_count;
	} chan_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	// Shadow channel table
	bit                 chan_present [NUM_CH];
	bit                 chan_active  [NUM_CH];
	logic [KIND_W-1:0]  chan_kind_tbl[NUM_CH];
	bit   [OSINK_W-1:0] chan_sinks   [NUM_CH];

	chan_result_t expected_results[$];
	chan_result_t mon_want;
	chan_result_t mon_got;

	int  mismatch_count = 0;
	int  idle_cycles    = 0;
	int  rx_hold        = 0;
	int  rx_pick        = 0;
	bit  tx_gap_on      = 1'b1;
	bit  rx_stall_on    = 1'b1;

	channel_pool_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Table update and expected result for one accepted request
	function automatic chan_result_t predict_request(logic [REQ_W-1:0] req,
			logic [ID_W-1:0] id, logic [COUNT_W-1:0] count, logic act);
		chan_result_t r;
		int           t;
		int           last;
		bit           hit;
		r        = '0;
		r.status = ST_FAIL;
		hit      = 1'b0;
		case (req)
			REQ_ADD_RANGE: begin
				last = int'(id) + int'(count);
				for (t = int'(id); t < last && t < NUM_CH; t++) begin
					chan_present[t]  = 1'b1;
					chan_active[t]   = 1'b0;
					chan_kind_tbl[t] = KIND_PLAIN;
				end
				r.status = ST_OK;
			end
			REQ_QUERY: begin
				if (chan_present[id]) begin
					r.status    = ST_OK;
					r.is_active = chan_active[id];
				end
			end
			REQ_SET_ACTIVE: begin
				if (chan_present[id]) begin
					chan_active[id] = act;
					r.status        = ST_OK;
				end
			end
			REQ_SET_STD, REQ_SET_CAND: begin
				if (chan_present[id]) begin
					chan_kind_tbl[id] = (req == REQ_SET_STD) ? KIND_STD : KIND_CAND;
					r.status          = ST_OK;
				end
			end
			REQ_ADD_SINK: begin
				if (chan_present[id]) begin
					if (chan_sinks[id] != SINK_MAX)
						chan_sinks[id] = chan_sinks[id] + 1'b1;
					r.status = ST_OK;
				end
			end
			REQ_REM_SINK: begin
				if (chan_present[id]) begin
					if (chan_sinks[id] != '0)
						chan_sinks[id] = chan_sinks[id] - 1'b1;
					r.status = ST_OK;
				end
			end
			REQ_ALLOC_PLN, REQ_ALLOC_STD: begin
				// lowest present, inactive channel of the wanted kind
				for (t = 0; t < NUM_CH && !hit; t++) begin
					if (chan_present[t] && !chan_active[t]) begin
						if (req == REQ_ALLOC_PLN)
							hit = (chan_kind_tbl[t] == KIND_PLAIN);
						else
							hit = (chan_kind_tbl[t] == KIND_STD) ||
								(chan_kind_tbl[t] == KIND_CAND);
						if (hit) begin
							chan_active[t] = 1'b1;
							r.found_id     = t[ID_W-1:0];
							r.status       = ST_OK;
						end
					end
				end
			end
			REQ_INFO: begin
				if (chan_present[id]) begin
					r.status     = ST_OK;
					r.is_active  = chan_active[id];
					r.chan_kind  = chan_kind_tbl[id];
					r.sink_count = chan_sinks[id];
				end
			end
			default: begin
				// unused codes: no change, failure
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Mostly low ids and the table end, so most requests find a channel
	function automatic logic [ID_W-1:0] pick_chan_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return ID_W'($urandom_range(0, 15));
		else if (r < 70)
			return ID_W'($urandom_range(240, 255));
		return ID_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [COUNT_W-1:0] pick_range_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return COUNT_W'($urandom_range(1, 8));
		else if (r < 85)
			return COUNT_W'($urandom_range(0, 40));
		else if (r < 97)
			return COUNT_W'($urandom_range(41, 256));
		return COUNT_W'($urandom_range(257, 511));
	endfunction

	task automatic report_mismatch(input string what, input longint want,
			input longint got);
		$display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// One request transfer, then an optional gap with tvalid low
	task automatic send_request(input logic [REQ_W-1:0] req,
			input logic [ID_W-1:0] id, input logic [COUNT_W-1:0] count,
			input logic act);
		int gap;
		s_tdata  <= {2'b00, act, count, id, req};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_results.push_back(predict_request(req, id, count, act));
		gap = tx_gap_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off the input until every outstanding result has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_absent_channels();
		send_request(REQ_QUERY,      8'd0,   9'd0, 1'b0);
		send_request(REQ_SET_ACTIVE, 8'd255, 9'd0, 1'b1);
		send_request(REQ_SET_STD,    8'd128, 9'd0, 1'b0);
		send_request(REQ_SET_CAND,   8'd0,   9'd0, 1'b0);
		send_request(REQ_ADD_SINK,   8'd255, 9'd0, 1'b0);
		send_request(REQ_REM_SINK,   8'd7,   9'd0, 1'b0);
		send_request(REQ_INFO,       8'd0,   9'd0, 1'b0);
		send_request(REQ_ALLOC_PLN,  8'd0,   9'd0, 1'b0);
		send_request(REQ_ALLOC_STD,  8'd0,   9'd0, 1'b0);
		send_request(REQ_UNUSED_LO,  8'd0,   9'd0, 1'b1);
		send_request(REQ_UNUSED_HI,  8'd255, 9'd511, 1'b1);
	endtask

	task automatic test_table_ops();
		// range running past the table end, then an empty range
		send_request(REQ_ADD_RANGE,  8'd250, 9'd10, 1'b0);
		send_request(REQ_ADD_RANGE,  8'd0,   9'd0,  1'b0);
		send_request(REQ_INFO,       8'd0,   9'd0,  1'b0);
		send_request(REQ_ADD_RANGE,  8'd0,   9'd4,  1'b0);
		send_request(REQ_QUERY,      8'd0,   9'd0,  1'b0);
		send_request(REQ_SET_ACTIVE, 8'd1,   9'd0,  1'b1);
		send_request(REQ_QUERY,      8'd1,   9'd0,  1'b0);
		send_request(REQ_SET_STD,    8'd2,   9'd0,  1'b0);
		send_request(REQ_SET_CAND,   8'd3,   9'd0,  1'b0);
		// sink count floor
		send_request(REQ_ADD_SINK,   8'd0,   9'd0,  1'b0);
		send_request(REQ_INFO,       8'd0,   9'd0,  1'b0);
		send_request(REQ_REM_SINK,   8'd0,   9'd0,  1'b0);
		send_request(REQ_REM_SINK,   8'd0,   9'd0,  1'b0);
		send_request(REQ_INFO,       8'd0,   9'd0,  1'b0);
		// allocations until the standard/candidate pool runs dry
		send_request(REQ_ALLOC_PLN,  8'd0,   9'd0,  1'b0);
		send_request(REQ_ALLOC_PLN,  8'd0,   9'd0,  1'b0);
		send_request(REQ_ALLOC_STD,  8'd0,   9'd0,  1'b0);
		send_request(REQ_ALLOC_STD,  8'd0,   9'd0,  1'b0);
		send_request(REQ_ALLOC_STD,  8'd0,   9'd0,  1'b0);
		send_request(REQ_SET_ACTIVE, 8'd2,   9'd0,  1'b0);
		send_request(REQ_ALLOC_STD,  8'd0,   9'd0,  1'b0);
		send_request(REQ_INFO,       8'd3,   9'd0,  1'b0);
		// whole table, with the largest count the field holds
		send_request(REQ_ADD_RANGE,  8'd0,   9'd511, 1'b0);
		send_request(REQ_INFO,       8'd3,   9'd0,  1'b0);
		send_request(REQ_ALLOC_STD,  8'd0,   9'd0,  1'b0);
		send_request(REQ_ALLOC_PLN,  8'd0,   9'd0,  1'b1);
	endtask

	// Burst of sink updates on one channel, back to back
	task automatic test_sink_burst();
		int i;
		tx_gap_on   = 1'b0;
		rx_stall_on = 1'b0;
		for (i = 0; i < SINK_BURST; i++)
			send_request(REQ_ADD_SINK, 8'd9, 9'd0, 1'b0);
		send_request(REQ_INFO,     8'd9, 9'd0, 1'b0);
		send_request(REQ_REM_SINK, 8'd9, 9'd0, 1'b0);
		send_request(REQ_INFO,     8'd9, 9'd0, 1'b0);
		tx_gap_on   = 1'b1;
		rx_stall_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [REQ_W-1:0]   req;
		logic [ID_W-1:0]    id;
		logic [COUNT_W-1:0] count;
		logic               act;
		int                 r;
		int                 i;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_for_results();
			// a stretch with no gaps and no backpressure
			if (i == 600) begin
				tx_gap_on   = 1'b0;
				rx_stall_on = 1'b0;
			end
			if (i == 700) begin
				tx_gap_on   = 1'b1;
				rx_stall_on = 1'b1;
			end
			r     = $urandom_range(0, 99);
			id    = pick_chan_id();
			count = COUNT_W'($urandom_range(0, 511));
			act   = 1'($urandom_range(0, 1));
			if (r < 8) begin
				req   = REQ_ADD_RANGE;
				count = pick_range_count();
			end else if (r < 16)
				req = REQ_QUERY;
			else if (r < 28)
				req = REQ_SET_ACTIVE;
			else if (r < 36)
				req = REQ_SET_STD;
			else if (r < 44)
				req = REQ_SET_CAND;
			else if (r < 54)
				req = REQ_ADD_SINK;
			else if (r < 62)
				req = REQ_REM_SINK;
			else if (r < 74)
				req = REQ_ALLOC_PLN;
			else if (r < 86)
				req = REQ_ALLOC_STD;
			else if (r < 96)
				req = REQ_INFO;
			else
				req = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
			send_request(req, id, count, act);
		end
	endtask

	// Output backpressure: runs of ready high and low of random length
	always @(posedge clk) begin
		if (!rx_stall_on) begin
			m_tready <= 1'b1;
			rx_hold  = 0;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end else begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 60) begin
				m_tready <= 1'b1;
				rx_hold  = $urandom_range(0, 19);
			end else if (rx_pick < 92) begin
				m_tready <= 1'b0;
				rx_hold  = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b0;
				rx_hold  = $urandom_range(14, 39);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with none outstanding, status", 0, m_tdata[0]);
			end else begin
				mon_want            = expected_results.pop_front();
				mon_got.status      = m_tdata[0];
				mon_got.found_id    = m_tdata[8:1];
				mon_got.is_active   = m_tdata[9];
				mon_got.chan_kind   = m_tdata[11:10];
				mon_got.sink_count  = m_tdata[27:12];
				if (mon_got.status !== mon_want.status)
					report_mismatch("status", mon_want.status, mon_got.status);
				if (mon_got.found_id !== mon_want.found_id)
					report_mismatch("found_id", mon_want.found_id, mon_got.found_id);
				if (mon_got.is_active !== mon_want.is_active)
					report_mismatch("is_active", mon_want.is_active, mon_got.is_active);
				if (mon_got.chan_kind !== mon_want.chan_kind)
					report_mismatch("chan_kind", mon_want.chan_kind, mon_got.chan_kind);
				if (mon_got.sink_count !== mon_want.sink_count)
					report_mismatch("sink_count", mon_want.sink_count, mon_got.sink_count);
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_absent_channels();
		test_table_ops();
		test_sink_burst();
		test_random_traffic();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
src/cpa_pkg.sv
src/cpa_ctrl.sv
src/cpa_dp.sv
src/channel_pool_allocator_unit.sv
verif/tb_channel_pool_allocator_unit.sv
